// ===== design/alcf_pkg.sv =====
`timescale 1ns / 1ps

package alcf_pkg;

  // Opcodes of an input beat.
  localparam logic [1:0] OP_DECODE  = 2'd0;
  localparam logic [1:0] OP_CONCEAL = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned FADE_FRAMES = 128;
  localparam int unsigned FADE_SHIFT  = $clog2(FADE_FRAMES);
  localparam int unsigned GAIN_W      = $clog2(FADE_FRAMES + 1);
  localparam int unsigned PROD_W      = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned FRAME_W     = 2 * SAMPLE_W;

  // One frame on its way from the state update to the gain stage.
  typedef struct packed {
    logic                       is_dec;
    logic [GAIN_W-1:0]          gain;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } issue_t;

  // s * g / FADE_FRAMES, truncated toward zero.
  function automatic logic signed [SAMPLE_W-1:0] fade_scale(
    input logic signed [SAMPLE_W-1:0] s,
    input logic [GAIN_W-1:0]          g
  );
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] shifted;
    prod = s * $signed({1'b0, g});
    if (prod < 0) begin
      bias = prod + PROD_W'(FADE_FRAMES - 1);
    end else begin
      bias = prod;
    end
    shifted = bias >>> FADE_SHIFT;
    return shifted[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== design/alcf_tail_mem.sv =====
`timescale 1ns / 1ps

module alcf_tail_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/alcf_ctrl.sv =====
`timescale 1ns / 1ps

module alcf_ctrl #(
  parameter int unsigned TAIL_FRAMES = 128,
  localparam int unsigned PW = $clog2(TAIL_FRAMES),
  localparam int unsigned CW = $clog2(TAIL_FRAMES + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [1:0]                          opcode_i,
  input  logic signed [alcf_pkg::SAMPLE_W-1:0] left_i,
  input  logic signed [alcf_pkg::SAMPLE_W-1:0] right_i,
  input  logic                                block_end_i,
  input  logic                                gap_start_i,
  output alcf_pkg::issue_t                    issue_o,
  output logic [PW-1:0]                       issue_addr_o
);

  localparam int unsigned GW = alcf_pkg::GAIN_W;
  localparam logic [GW-1:0] FADE_G = GW'(alcf_pkg::FADE_FRAMES);

  logic [PW-1:0] wp_q, wp_d;
  logic [CW-1:0] bfc_q, bfc_d;
  logic [CW-1:0] tl_q, tl_d;
  logic [PW-1:0] ts_q, ts_d;
  logic [GW-1:0] rem_q, rem_d;
  logic [GW-1:0] pos_q, pos_d;
  logic [PW-1:0] rpt_q, rpt_d;

  logic [PW-1:0] wp_inc;
  logic [CW-1:0] bfc_inc;
  logic [CW:0]   wp_ext;
  logic [GW-1:0] pos_eff;
  logic [PW-1:0] rpt_base;
  logic [PW-1:0] rpt_eff;
  logic [CW-1:0] rpt_next;
  logic [PW:0]   idx_sum;

  always_comb begin
    wp_d  = wp_q;
    bfc_d = bfc_q;
    tl_d  = tl_q;
    ts_d  = ts_q;
    rem_d = rem_q;
    pos_d = pos_q;
    rpt_d = rpt_q;

    issue_o.is_dec = (opcode_i == alcf_pkg::OP_DECODE);
    issue_o.gain   = '0;
    issue_o.left   = left_i;
    issue_o.right  = right_i;
    issue_addr_o   = wp_q;

    wp_inc   = (wp_q == PW'(TAIL_FRAMES - 1)) ? '0 : wp_q + PW'(1);
    bfc_inc  = (bfc_q == CW'(TAIL_FRAMES)) ? bfc_q : bfc_q + CW'(1);
    wp_ext   = (CW + 1)'(wp_inc);
    pos_eff  = gap_start_i ? '0 : pos_q;
    rpt_base = gap_start_i ? '0 : rpt_q;
    rpt_eff  = (CW'(rpt_base) >= tl_q) ? '0 : rpt_base;
    rpt_next = CW'(rpt_eff) + CW'(1);
    idx_sum  = (PW + 1)'(ts_q) + (PW + 1)'(rpt_eff);

    case (opcode_i)
      alcf_pkg::OP_DECODE: begin
        if (rem_q != '0) begin
          issue_o.gain = FADE_G - rem_q + GW'(1);
          rem_d        = rem_q - GW'(1);
        end else begin
          issue_o.gain = FADE_G;
        end
        wp_d = wp_inc;
        if (block_end_i) begin
          tl_d  = bfc_inc;
          bfc_d = '0;
          // Oldest tail slot sits tail_length slots behind the next write.
          if (wp_ext >= (CW + 1)'(bfc_inc)) begin
            ts_d = PW'(wp_ext - (CW + 1)'(bfc_inc));
          end else begin
            ts_d = PW'(wp_ext + (CW + 1)'(TAIL_FRAMES) - (CW + 1)'(bfc_inc));
          end
        end else begin
          bfc_d = bfc_inc;
        end
      end
      alcf_pkg::OP_CONCEAL: begin
        rpt_d = rpt_base;
        if (tl_q != '0 && pos_eff < FADE_G) begin
          issue_o.gain = FADE_G - pos_eff;
          if (idx_sum >= (PW + 1)'(TAIL_FRAMES)) begin
            issue_addr_o = PW'(idx_sum - (PW + 1)'(TAIL_FRAMES));
          end else begin
            issue_addr_o = PW'(idx_sum);
          end
          rpt_d = (rpt_next >= tl_q) ? '0 : PW'(rpt_next);
        end
        pos_d = (pos_eff < FADE_G) ? pos_eff + GW'(1) : pos_eff;
        rem_d = FADE_G;
      end
      alcf_pkg::OP_RESTART: begin
        wp_d  = '0;
        bfc_d = '0;
        tl_d  = '0;
        ts_d  = '0;
        rem_d = '0;
        pos_d = '0;
        rpt_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      bfc_q <= '0;
      tl_q  <= '0;
      ts_q  <= '0;
      rem_q <= '0;
      pos_q <= '0;
      rpt_q <= '0;
    end else if (accept_i) begin
      wp_q  <= wp_d;
      bfc_q <= bfc_d;
      tl_q  <= tl_d;
      ts_q  <= ts_d;
      rem_q <= rem_d;
      pos_q <= pos_d;
      rpt_q <= rpt_d;
    end
  end

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PW + 1)'(wp_q) < (PW + 1)'(TAIL_FRAMES))
    else $error("write pointer left the ring");

  a_tail_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tl_q <= CW'(TAIL_FRAMES) && (PW + 1)'(ts_q) < (PW + 1)'(TAIL_FRAMES))
    else $error("tail length or start out of range");

endmodule

// ===== design/alcf_fade.sv =====
`timescale 1ns / 1ps

module alcf_fade #(
  parameter int unsigned AW = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                issue_valid_i,
  input  alcf_pkg::issue_t                    issue_i,
  input  logic [AW-1:0]                       issue_addr_i,
  output logic                                pipe_ready_o,
  output logic                                mem_we_o,
  output logic [AW-1:0]                       mem_waddr_o,
  output logic [alcf_pkg::FRAME_W-1:0]        mem_wdata_o,
  output logic                                mem_re_o,
  output logic [AW-1:0]                       mem_raddr_o,
  input  logic [alcf_pkg::FRAME_W-1:0]        mem_rdata_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [alcf_pkg::SAMPLE_W-1:0] out_left_o,
  output logic signed [alcf_pkg::SAMPLE_W-1:0] out_right_o,
  output logic                                out_concealed_o
);

  localparam int unsigned SW = alcf_pkg::SAMPLE_W;

  logic                         s1_valid_q;
  alcf_pkg::issue_t             s1_q;
  logic [AW-1:0]                s1_addr_q;
  logic                         fwd_q;
  logic [alcf_pkg::FRAME_W-1:0] fwd_data_q;
  logic                         fwd_d;

  logic                         out_valid_q;
  logic signed [SW-1:0]         out_left_q;
  logic signed [SW-1:0]         out_right_q;
  logic                         out_conc_q;

  logic                         adv;
  logic [alcf_pkg::FRAME_W-1:0] src;
  logic signed [SW-1:0]         scaled_l;
  logic signed [SW-1:0]         scaled_r;

  assign adv          = s1_valid_q && (!out_valid_q || out_ready_i);
  assign pipe_ready_o = !s1_valid_q || adv;

  // A concealment read that hits the slot being written this cycle takes
  // the write data instead of the stale memory word. A silence beat carries
  // zero samples whatever the memory holds.
  assign src = s1_q.is_dec ? {s1_q.right, s1_q.left}
             : (s1_q.gain == '0) ? '0
             : (fwd_q ? fwd_data_q : mem_rdata_i);

  assign scaled_l = alcf_pkg::fade_scale(src[SW-1:0], s1_q.gain);
  assign scaled_r = alcf_pkg::fade_scale(src[2*SW-1:SW], s1_q.gain);

  assign mem_we_o    = adv && s1_q.is_dec;
  assign mem_waddr_o = s1_addr_q;
  assign mem_wdata_o = {scaled_r, scaled_l};
  assign mem_re_o    = issue_valid_i && !issue_i.is_dec;
  assign mem_raddr_o = issue_addr_i;
  assign fwd_d       = mem_we_o && mem_re_o && (mem_waddr_o == mem_raddr_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue_valid_i) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= fwd_d;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_valid_i) begin
      s1_q       <= issue_i;
      s1_addr_q  <= issue_addr_i;
      fwd_data_q <= mem_wdata_o;
    end
    if (adv) begin
      out_left_q  <= scaled_l;
      out_right_q <= scaled_r;
      out_conc_q  <= !s1_q.is_dec;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_left_o      = out_left_q;
  assign out_right_o     = out_right_q;
  assign out_concealed_o = out_conc_q;

  a_flag_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q && (out_conc_q == !$past(s1_q.is_dec)))
    else $error("concealed flag does not match the beat kind");

  a_silence_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !s1_q.is_dec && s1_q.gain == '0) |=>
      out_left_q == '0 && out_right_q == '0)
    else $error("silence beat carries nonzero samples");

  a_fwd_conceal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fwd_q && s1_valid_q) |-> !s1_q.is_dec)
    else $error("forwarding armed for a decoded beat");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_valid_i |-> pipe_ready_o)
    else $error("beat issued while the gain stage is full");

endmodule

// ===== design/audio_loss_concealment_fade.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Signals                         Contents
// s_axis   in   tvalid tready tdata tuser tlast left, right samples; opcode, gap_start;
//                                               block_end
// m_axis   out  tvalid tready tdata tuser       out_left, out_right; concealed
//
// Every beat is accepted while s_axis_tready is high; decoded and concealment beats
// pass the gain stage and output registers, one per cycle while m_axis_tready stays high.
// The tail memory read is registered together with the gain stage.
// Restart clears control state at acceptance; unused opcodes leave it as is. Neither gives a beat.
// The tail memory has no reset; control state clears on rst_ni.
// A stall on m_axis holds one beat in the gain stage and one in the output
// register before s_axis_tready drops.
module audio_loss_concealment_fade #(
  parameter int unsigned TAIL_FRAMES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] left_sample, [31:16] right_sample
  input  logic [2:0]  s_axis_tuser,  // [1:0] opcode, [2] gap_start
  input  logic        s_axis_tlast,  // block_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [15:0] out_left, [31:16] out_right
  output logic [0:0]  m_axis_tuser   // [0] concealed
);

  localparam int unsigned PW = $clog2(TAIL_FRAMES);
  localparam int unsigned SW = alcf_pkg::SAMPLE_W;
  localparam int unsigned FW = alcf_pkg::FRAME_W;

  logic             accept;
  logic             issue_valid;
  alcf_pkg::issue_t issue;
  logic [PW-1:0]    issue_addr;
  logic             pipe_ready;
  logic             mem_we;
  logic [PW-1:0]    mem_waddr;
  logic [FW-1:0]    mem_wdata;
  logic             mem_re;
  logic [PW-1:0]    mem_raddr;
  logic [FW-1:0]    mem_rdata;
  logic signed [SW-1:0] out_left;
  logic signed [SW-1:0] out_right;
  logic             out_conc;

  assign s_axis_tready = pipe_ready;
  assign accept        = s_axis_tvalid && pipe_ready;
  assign issue_valid   = accept && (s_axis_tuser[1:0] == alcf_pkg::OP_DECODE ||
                                    s_axis_tuser[1:0] == alcf_pkg::OP_CONCEAL);

  alcf_ctrl #(
    .TAIL_FRAMES (TAIL_FRAMES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .opcode_i     (s_axis_tuser[1:0]),
    .left_i       (s_axis_tdata[SW-1:0]),
    .right_i      (s_axis_tdata[2*SW-1:SW]),
    .block_end_i  (s_axis_tlast),
    .gap_start_i  (s_axis_tuser[2]),
    .issue_o      (issue),
    .issue_addr_o (issue_addr)
  );

  alcf_tail_mem #(
    .DEPTH (TAIL_FRAMES),
    .AW    (PW),
    .DW    (FW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  alcf_fade #(
    .AW (PW)
  ) u_fade (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .issue_valid_i   (issue_valid),
    .issue_i         (issue),
    .issue_addr_i    (issue_addr),
    .pipe_ready_o    (pipe_ready),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_left_o      (out_left),
    .out_right_o     (out_right),
    .out_concealed_o (out_conc)
  );

  assign m_axis_tdata    = {out_right, out_left};
  assign m_axis_tuser[0] = out_conc;

endmodule
